@@ hdl/ocs_to_world_transform_defines.svh @@
// ----------------------------------------------------------------------------
// OCS to world transform assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef OCS_TO_WORLD_TRANSFORM_DEFINES_SVH
`define OCS_TO_WORLD_TRANSFORM_DEFINES_SVH

// same-cycle implication
`define OCS_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ocs assertion failed");

// next-cycle implication
`define OCS_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ocs assertion failed");

`endif

@@ hdl/ocs_pkg.sv @@
// ----------------------------------------------------------------------------
// OCS package
// Widths, fixed-point shifts and the sideband carried down the pipeline.
// ----------------------------------------------------------------------------
package ocs_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int AXIS_WIDTH  = 18;
  localparam int UNIT_W      = 32;   // unit vector components, Q.30
  localparam int UNIT_FRAC   = 30;
  localparam int MAG_W       = 28;   // component magnitude before normalize
  localparam int RAD_W       = 64;   // sqrt radicand
  localparam int ROOT_W      = 32;
  localparam int DEN_W       = ROOT_W;
  localparam int Q_W         = 32;
  localparam int NUM_W       = DEN_W + Q_W;
  localparam int AX_SHIFT1   = 43;
  localparam int AX_SHIFT2   = 35;
  localparam int LEN_SHIFT1  = 26;
  localparam int LEN_SHIFT2  = 10;
  localparam int CY_SHIFT    = 22;
  localparam int N_SHIFT     = 14;
  localparam int NEAR_LIMIT  = 1024;  // 1/64 in Q1.16

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] px;
    logic signed [COORD_WIDTH-1:0] py;
    logic signed [COORD_WIDTH-1:0] pz;
    logic [2:0][AXIS_WIDTH-1:0]    n;
    logic [2:0]                    cneg;
    logic [2:0][MAG_W-1:0]         cmag;
    logic [2:0][UNIT_W-1:0]        ux;
    logic                          degen;
  } sb_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] wx;
    logic [COORD_WIDTH-1:0] wy;
    logic [COORD_WIDTH-1:0] wz;
    logic                   degen;
  } res_t;

endpackage

@@ hdl/ocs_in_if.sv @@
// ----------------------------------------------------------------------------
// OCS input channel
// Point and extrusion normal beat with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ocs_in_if;
  import ocs_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;
  logic signed [AXIS_WIDTH-1:0]  axis_x;
  logic signed [AXIS_WIDTH-1:0]  axis_y;
  logic signed [AXIS_WIDTH-1:0]  axis_z;

  modport source (output valid, point_x, point_y, point_z, axis_x, axis_y, axis_z,
                  input ready);
  modport sink (input valid, point_x, point_y, point_z, axis_x, axis_y, axis_z,
                output ready);
endinterface

@@ hdl/ocs_out_if.sv @@
// ----------------------------------------------------------------------------
// OCS output channel
// World point beat with degenerate flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ocs_out_if;
  import ocs_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] world_x;
  logic signed [COORD_WIDTH-1:0] world_y;
  logic signed [COORD_WIDTH-1:0] world_z;
  logic                          degenerate;

  modport source (output valid, world_x, world_y, world_z, degenerate, input ready);
  modport sink (input valid, world_x, world_y, world_z, degenerate, output ready);
endinterface

@@ hdl/ocs_sqrt.sv @@
// ----------------------------------------------------------------------------
// OCS pipelined square root
// Floor square root, one root bit per register stage, sideband carried along.
// ----------------------------------------------------------------------------
module ocs_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  ocs_pkg::sb_t                in_sb,
  input  logic [ocs_pkg::RAD_W-1:0]   rad,
  output logic                        out_valid,
  output ocs_pkg::sb_t                out_sb,
  output logic [ocs_pkg::ROOT_W-1:0]  root
);
  import ocs_pkg::*;

  localparam int REM_W = ROOT_W + 2;

  logic [ROOT_W-1:0] st_root [ROOT_W];
  logic [REM_W-1:0]  st_rem  [ROOT_W];
  logic [RAD_W-1:0]  st_rad  [ROOT_W];
  sb_t               st_sb   [ROOT_W];
  logic              st_v    [ROOT_W];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_step
    logic [ROOT_W-1:0] p_root;
    logic [REM_W-1:0]  p_rem;
    logic [RAD_W-1:0]  p_rad;
    sb_t               p_sb;
    logic              p_v;
    logic [REM_W+1:0]  nrem;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              ge;

    if (g == 0) begin : g_first
      assign p_root = '0;
      assign p_rem  = '0;
      assign p_rad  = rad;
      assign p_sb   = in_sb;
      assign p_v    = in_valid;
    end else begin : g_next
      assign p_root = st_root[g-1];
      assign p_rem  = st_rem[g-1];
      assign p_rad  = st_rad[g-1];
      assign p_sb   = st_sb[g-1];
      assign p_v    = st_v[g-1];
    end

    assign nrem  = {p_rem, p_rad[RAD_W-1 -: 2]};
    assign trial = {2'b00, p_root, 2'b01};
    assign diff  = nrem - trial;
    assign ge    = (nrem >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[g] <= 1'b0;
      end else if (en) begin
        st_v[g] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_sb[g]  <= p_sb;
        st_rad[g] <= {p_rad[RAD_W-3:0], 2'b00};
        st_rem[g] <= ge ? diff[REM_W-1:0] : nrem[REM_W-1:0];
        st_root[g] <= {p_root[ROOT_W-2:0], ge};
      end
    end
  end

  assign out_valid = st_v[ROOT_W-1];
  assign out_sb    = st_sb[ROOT_W-1];
  assign root      = st_root[ROOT_W-1];

endmodule

@@ hdl/ocs_div3.sv @@
// ----------------------------------------------------------------------------
// OCS pipelined three-lane divider
// Restoring division of three numerators by one shared divisor, one
// quotient bit per register stage.
// ----------------------------------------------------------------------------
module ocs_div3 (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  ocs_pkg::sb_t                      in_sb,
  input  logic [2:0][ocs_pkg::NUM_W-1:0]    num,
  input  logic [ocs_pkg::DEN_W-1:0]         den,
  output logic                              out_valid,
  output ocs_pkg::sb_t                      out_sb,
  output logic [2:0][ocs_pkg::Q_W-1:0]      quo
);
  import ocs_pkg::*;

  logic [DEN_W-1:0] st_rem [Q_W][3];
  logic [Q_W-1:0]   st_lo  [Q_W][3];
  logic [Q_W-1:0]   st_q   [Q_W][3];
  logic [DEN_W-1:0] st_den [Q_W];
  sb_t              st_sb  [Q_W];
  logic             st_v   [Q_W];

  for (genvar g = 0; g < Q_W; g++) begin : g_step
    logic [DEN_W-1:0] p_rem [3];
    logic [Q_W-1:0]   p_lo  [3];
    logic [Q_W-1:0]   p_q   [3];
    logic [DEN_W-1:0] p_den;
    sb_t              p_sb;
    logic             p_v;
    logic [DEN_W:0]   t     [3];
    logic [DEN_W:0]   diff  [3];
    logic             ge    [3];

    if (g == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          p_rem[l] = num[l][NUM_W-1 -: DEN_W];
          p_lo[l]  = num[l][Q_W-1:0];
          p_q[l]   = '0;
        end
      end
      assign p_den = den;
      assign p_sb  = in_sb;
      assign p_v   = in_valid;
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          p_rem[l] = st_rem[g-1][l];
          p_lo[l]  = st_lo[g-1][l];
          p_q[l]   = st_q[g-1][l];
        end
      end
      assign p_den = st_den[g-1];
      assign p_sb  = st_sb[g-1];
      assign p_v   = st_v[g-1];
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        t[l]    = {p_rem[l], p_lo[l][Q_W-1]};
        diff[l] = t[l] - {1'b0, p_den};
        ge[l]   = (t[l] >= {1'b0, p_den});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[g] <= 1'b0;
      end else if (en) begin
        st_v[g] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_sb[g]  <= p_sb;
        st_den[g] <= p_den;
        for (int l = 0; l < 3; l++) begin
          st_rem[g][l] <= ge[l] ? diff[l][DEN_W-1:0] : t[l][DEN_W-1:0];
          st_lo[g][l]  <= {p_lo[l][Q_W-2:0], 1'b0};
          st_q[g][l]   <= {p_q[l][Q_W-2:0], ge[l]};
        end
      end
    end
  end

  assign out_valid = st_v[Q_W-1];
  assign out_sb    = st_sb[Q_W-1];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      quo[l] = st_q[Q_W-1][l];
    end
  end

endmodule

@@ hdl/ocs_to_world_transform.sv @@
// ----------------------------------------------------------------------------
// OCS to world transform
// Maps a point from an entity's object coordinate system to world
// coordinates by the arbitrary-axis rule.
//
// point_in carries one point (Q16.16) and its extrusion normal (Q1.16) per
// beat; world_out returns the world point (Q16.16, rounded, saturated) and
// a degenerate flag, one beat per input beat, in order.
// Two 32-stage square roots and two 32-stage dividers (one quotient bit per
// stage) make up most of the pipeline, with 16 stages of multiply, sum and
// round around them. Throughput is one beat per cycle while point_in.ready
// is high, and the whole pipeline advances together;
// a two-entry output queue lets it keep taking beats while one result waits.
// point_in.ready drops only when both queue entries are held.
// Reset (rst, synchronous) clears all valid bits and the queue; nothing else
// needs initializing. A stall on world_out loses and repeats nothing.
// A zero normal gives degenerate = 1 and a zero world point.
// ----------------------------------------------------------------------------
`include "ocs_to_world_transform_defines.svh"

module ocs_to_world_transform (
  input  logic      clk,
  input  logic      rst,
  ocs_in_if.sink    point_in,
  ocs_out_if.source world_out
);
  import ocs_pkg::*;

  localparam int PR_W  = AXIS_WIDTH + UNIT_W;
  localparam int CD_W  = PR_W + 1;
  localparam int SQ1_W = 2 * AXIS_WIDTH;
  localparam int SQ2_W = 2 * MAG_W;
  localparam int PW    = UNIT_W + COORD_WIDTH;
  localparam int SW    = PW + 2;
  localparam int RM_W  = SW - UNIT_FRAC;

  localparam logic [AXIS_WIDTH-1:0] NEAR_LIM = AXIS_WIDTH'(NEAR_LIMIT);
  localparam logic signed [CD_W-1:0] CY_HALF = CD_W'(1) << (CY_SHIFT - 1);
  localparam logic signed [SW-1:0]   RND_HALF = SW'(1) << (UNIT_FRAC - 1);
  localparam logic [RM_W-1:0] POS_MAX = RM_W'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
  localparam logic [RM_W-1:0] NEG_MAX = RM_W'(64'd1 << (COORD_WIDTH - 1));
  localparam logic [COORD_WIDTH-1:0] SAT_HI = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] SAT_LO = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic [1:0] Q_FULL = 2'd2;

  function automatic logic [AXIS_WIDTH-1:0] amag(input logic signed [AXIS_WIDTH-1:0] v);
    return v[AXIS_WIDTH-1] ? AXIS_WIDTH'(-v) : AXIS_WIDTH'(v);
  endfunction

  logic adv;

  // front: axis select, squares, length radicand
  logic f1_v, f2_v, f3_v;
  sb_t  f1_next, f1_sb, f2_sb, f3_sb, f3_next;
  logic [SQ1_W-1:0] f2_sq [3];
  logic [SQ1_W+1:0] f2_sum;
  logic [RAD_W-1:0] f3_rad;
  logic [AXIS_WIDTH-1:0] mx, my, mz;
  logic near;

  always_comb begin
    mx = amag(point_in.axis_x);
    my = amag(point_in.axis_y);
    mz = amag(point_in.axis_z);
    near = (mx < NEAR_LIM) && (my < NEAR_LIM);
    f1_next       = '0;
    f1_next.px    = point_in.point_x;
    f1_next.py    = point_in.point_y;
    f1_next.pz    = point_in.point_z;
    f1_next.n[0]  = point_in.axis_x;
    f1_next.n[1]  = point_in.axis_y;
    f1_next.n[2]  = point_in.axis_z;
    if (near) begin
      f1_next.cmag[0] = MAG_W'(mz);
      f1_next.cneg[0] = point_in.axis_z[AXIS_WIDTH-1];
      f1_next.cmag[2] = MAG_W'(mx);
      f1_next.cneg[2] = (point_in.axis_x > 0);
    end else begin
      f1_next.cmag[0] = MAG_W'(my);
      f1_next.cneg[0] = (point_in.axis_y > 0);
      f1_next.cmag[1] = MAG_W'(mx);
      f1_next.cneg[1] = point_in.axis_x[AXIS_WIDTH-1];
    end
  end

  assign f2_sum = (SQ1_W+2)'(f2_sq[0]) + (SQ1_W+2)'(f2_sq[1]) + (SQ1_W+2)'(f2_sq[2]);

  always_comb begin
    f3_next       = f2_sb;
    f3_next.degen = (f2_sum == '0);
  end

  // first normalize
  logic s1_v, g1_v, d1_v, g2_v;
  sb_t  s1_sb, g1_sb, d1_sb, g2_sb, g2_next;
  logic [ROOT_W-1:0] s1_root;
  logic [2:0][NUM_W-1:0] g1_num;
  logic [DEN_W-1:0] g1_den;
  logic [2:0][Q_W-1:0] d1_q;

  ocs_sqrt u_sqrt1 (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(f3_v), .in_sb(f3_sb), .rad(f3_rad),
    .out_valid(s1_v), .out_sb(s1_sb), .root(s1_root)
  );

  ocs_div3 u_div1 (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(g1_v), .in_sb(g1_sb), .num(g1_num), .den(g1_den),
    .out_valid(d1_v), .out_sb(d1_sb), .quo(d1_q)
  );

  always_comb begin
    g2_next = d1_sb;
    for (int i = 0; i < 3; i++) begin
      g2_next.ux[i] = d1_sb.cneg[i] ? ('0 - d1_q[i]) : d1_q[i];
    end
  end

  // y axis cross product
  logic h1_v, h2_v, h3_v, h4_v, h5_v;
  sb_t  h1_sb, h2_sb, h3_sb, h4_sb, h5_sb, h3_next, h5_next;
  logic signed [AXIS_WIDTH-1:0] ns [3];
  logic signed [UNIT_W-1:0]     us [3];
  logic signed [PR_W-1:0] h1_pr [6];
  logic signed [CD_W-1:0] h2_d [3];
  logic signed [CD_W-1:0] h2_r [3];
  logic [SQ2_W-1:0] h4_sq [3];
  logic [SQ2_W+1:0] h4_sum;
  logic [RAD_W-1:0] h5_rad;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ns[i] = $signed(g2_sb.n[i]);
      us[i] = $signed(g2_sb.ux[i]);
    end
  end

  always_comb begin
    h3_next = h2_sb;
    for (int i = 0; i < 3; i++) begin
      h2_r[i] = h2_d[i][CD_W-1] ? (CY_HALF - h2_d[i]) : (h2_d[i] + CY_HALF);
      h3_next.cmag[i] = h2_r[i][CY_SHIFT +: MAG_W];
      h3_next.cneg[i] = h2_d[i][CD_W-1];
    end
  end

  assign h4_sum = (SQ2_W+2)'(h4_sq[0]) + (SQ2_W+2)'(h4_sq[1]) + (SQ2_W+2)'(h4_sq[2]);

  always_comb begin
    h5_next       = h4_sb;
    h5_next.degen = h4_sb.degen | (h4_sum == '0);
  end

  // second normalize
  logic s2_v, k1_v, d2_v, k2_v;
  sb_t  s2_sb, k1_sb, d2_sb, k2_sb;
  logic [ROOT_W-1:0] s2_root;
  logic [2:0][NUM_W-1:0] k1_num;
  logic [DEN_W-1:0] k1_den;
  logic [2:0][Q_W-1:0] d2_q;
  logic [UNIT_W-1:0] k2_uy [3];
  logic signed [UNIT_W-1:0] k2_wn [3];

  ocs_sqrt u_sqrt2 (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(h5_v), .in_sb(h5_sb), .rad(h5_rad),
    .out_valid(s2_v), .out_sb(s2_sb), .root(s2_root)
  );

  ocs_div3 u_div2 (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(k1_v), .in_sb(k1_sb), .num(k1_num), .den(k1_den),
    .out_valid(d2_v), .out_sb(d2_sb), .quo(d2_q)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      k2_wn[i] = UNIT_W'($signed(k2_sb.n[i])) <<< N_SHIFT;
    end
  end

  // output products, sum, round, saturate
  logic m1_v, m2_v, m3_v, m4_v;
  logic m1_dg, m2_dg, m3_dg;
  logic signed [PW-1:0] m1_pa [3];
  logic signed [PW-1:0] m1_pb [3];
  logic signed [PW-1:0] m1_pc [3];
  logic signed [SW-1:0] m2_s [3];
  logic signed [SW-1:0] m2_r [3];
  logic [RM_W-1:0] m3_rm [3];
  logic [2:0] m3_neg;
  logic [COORD_WIDTH-1:0] m3_w [3];
  res_t m4_res;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m2_r[i] = m2_s[i][SW-1] ? (RND_HALF - m2_s[i]) : (m2_s[i] + RND_HALF);
      if (m3_neg[i]) begin
        m3_w[i] = (m3_rm[i] > NEG_MAX) ? SAT_LO : ('0 - m3_rm[i][COORD_WIDTH-1:0]);
      end else begin
        m3_w[i] = (m3_rm[i] > POS_MAX) ? SAT_HI : m3_rm[i][COORD_WIDTH-1:0];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0; f2_v <= 1'b0; f3_v <= 1'b0;
      g1_v <= 1'b0; g2_v <= 1'b0;
      h1_v <= 1'b0; h2_v <= 1'b0; h3_v <= 1'b0; h4_v <= 1'b0; h5_v <= 1'b0;
      k1_v <= 1'b0; k2_v <= 1'b0;
      m1_v <= 1'b0; m2_v <= 1'b0; m3_v <= 1'b0; m4_v <= 1'b0;
    end else if (adv) begin
      f1_v <= point_in.valid; f2_v <= f1_v; f3_v <= f2_v;
      g1_v <= s1_v; g2_v <= d1_v;
      h1_v <= g2_v; h2_v <= h1_v; h3_v <= h2_v; h4_v <= h3_v; h5_v <= h4_v;
      k1_v <= s2_v; k2_v <= d2_v;
      m1_v <= k2_v; m2_v <= m1_v; m3_v <= m2_v; m4_v <= m3_v;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      f1_sb <= f1_next;
      f2_sb <= f1_sb;
      for (int i = 0; i < 3; i++) begin
        f2_sq[i] <= f1_sb.cmag[i][AXIS_WIDTH-1:0] * f1_sb.cmag[i][AXIS_WIDTH-1:0];
      end
      f3_sb       <= f3_next;
      f3_rad      <= RAD_W'(f2_sum) << LEN_SHIFT1;

      g1_sb  <= s1_sb;
      g1_den <= s1_root;
      for (int i = 0; i < 3; i++) begin
        g1_num[i] <= (NUM_W'(s1_sb.cmag[i]) << AX_SHIFT1) + NUM_W'(s1_root >> 1);
      end
      g2_sb <= g2_next;

      h1_sb    <= g2_sb;
      h1_pr[0] <= ns[1] * us[2];
      h1_pr[1] <= ns[2] * us[1];
      h1_pr[2] <= ns[2] * us[0];
      h1_pr[3] <= ns[0] * us[2];
      h1_pr[4] <= ns[0] * us[1];
      h1_pr[5] <= ns[1] * us[0];
      h2_sb <= h1_sb;
      for (int i = 0; i < 3; i++) begin
        h2_d[i] <= CD_W'(h1_pr[2*i]) - CD_W'(h1_pr[2*i+1]);
      end
      h3_sb <= h3_next;
      h4_sb <= h3_sb;
      for (int i = 0; i < 3; i++) begin
        h4_sq[i] <= h3_sb.cmag[i] * h3_sb.cmag[i];
      end
      h5_sb       <= h5_next;
      h5_rad      <= RAD_W'(h4_sum) << LEN_SHIFT2;

      k1_sb  <= s2_sb;
      k1_den <= s2_root;
      for (int i = 0; i < 3; i++) begin
        k1_num[i] <= (NUM_W'(s2_sb.cmag[i]) << AX_SHIFT2) + NUM_W'(s2_root >> 1);
      end
      k2_sb <= d2_sb;
      for (int i = 0; i < 3; i++) begin
        k2_uy[i] <= d2_sb.cneg[i] ? ('0 - d2_q[i]) : d2_q[i];
      end

      m1_dg <= k2_sb.degen;
      for (int i = 0; i < 3; i++) begin
        m1_pa[i] <= $signed(k2_sb.ux[i]) * k2_sb.px;
        m1_pb[i] <= $signed(k2_uy[i]) * k2_sb.py;
        m1_pc[i] <= k2_wn[i] * k2_sb.pz;
      end
      m2_dg <= m1_dg;
      for (int i = 0; i < 3; i++) begin
        m2_s[i] <= SW'(m1_pa[i]) + SW'(m1_pb[i]) + SW'(m1_pc[i]);
      end
      m3_dg <= m2_dg;
      for (int i = 0; i < 3; i++) begin
        m3_rm[i]  <= m2_r[i][SW-1:UNIT_FRAC];
        m3_neg[i] <= m2_s[i][SW-1];
      end
      m4_res.degen <= m3_dg;
      m4_res.wx    <= m3_dg ? '0 : m3_w[0];
      m4_res.wy    <= m3_dg ? '0 : m3_w[1];
      m4_res.wz    <= m3_dg ? '0 : m3_w[2];
    end
  end

  // two-entry output queue
  res_t q0, q1;
  logic [1:0] q_cnt;
  logic push, pop;

  assign adv  = (q_cnt != Q_FULL);
  assign push = adv & m4_v;
  assign pop  = world_out.valid & world_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= '0;
    end else begin
      q_cnt <= q_cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push && (q_cnt == 2'd0 || (q_cnt == 2'd1 && pop))) begin
      q0 <= m4_res;
    end else if (pop) begin
      q0 <= q1;
    end
    if (push && q_cnt == 2'd1 && !pop) begin
      q1 <= m4_res;
    end
  end

  assign point_in.ready       = adv;
  assign world_out.valid      = (q_cnt != 2'd0);
  assign world_out.world_x    = q0.wx;
  assign world_out.world_y    = q0.wy;
  assign world_out.world_z    = q0.wz;
  assign world_out.degenerate = q0.degen;

  `OCS_AST_IMP(a_q_bound, 1'b1, q_cnt != 2'd3)
  `OCS_AST_IMP(a_no_push_full, m4_v && q_cnt == Q_FULL, !push)
  `OCS_AST_NXT(a_full_blocks, q_cnt == Q_FULL && !pop, !point_in.ready)
  `OCS_AST_IMP(a_degen_zero, world_out.valid && world_out.degenerate,
               world_out.world_x == 0 && world_out.world_y == 0 && world_out.world_z == 0)

endmodule
